FILE: design/oaids_pkg.sv
// Package for the ordered array store: sizes, action and status codes,
// controller states and the command and status structs between modules.
// Depends on nothing.
package oaids_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_POS   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SRCH = 2'd2
  } state_e;

  typedef struct packed {
    logic req_load;
    logic commit;
    logic match_load;
    logic srch_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_search;
  } dp_stat_t;

endpackage

FILE: design/oaids_ctrl.sv
// Controller state machine of the ordered array store.
// Depends on oaids_pkg for the state type and the command and status structs.
module oaids_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  oaids_pkg::dp_stat_t  stat_i,
  output oaids_pkg::ctrl_cmd_t cmd_o
);

  oaids_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oaids_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = oaids_pkg::S_EXEC;
        end
      end
      oaids_pkg::S_EXEC: begin
        if (stat_i.is_search) begin
          state_d = oaids_pkg::S_SRCH;
        end else if (out_free) begin
          state_d = oaids_pkg::S_IDLE;
        end
      end
      oaids_pkg::S_SRCH: begin
        if (out_free) begin
          state_d = oaids_pkg::S_IDLE;
        end
      end
      default: state_d = oaids_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      oaids_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.req_load = in_valid_i;
      end
      oaids_pkg::S_EXEC: begin
        cmd_o.match_load = stat_i.is_search;
        cmd_o.commit     = !stat_i.is_search && out_free;
      end
      oaids_pkg::S_SRCH: begin
        cmd_o.srch_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit || cmd_o.srch_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oaids_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/oaids_dp.sv
// Datapath of the ordered array store: request register, entry row, fill
// count, match vector and result register. Depends on oaids_pkg.
module oaids_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  oaids_pkg::ctrl_cmd_t                cmd_i,
  output oaids_pkg::dp_stat_t                 stat_o,
  input  logic [oaids_pkg::ACT_W-1:0]         action_i,
  input  logic [oaids_pkg::IDX_W-1:0]         position_i,
  input  logic signed [oaids_pkg::DATA_W-1:0] value_i,
  output logic [oaids_pkg::STAT_W-1:0]        status_o,
  output logic [oaids_pkg::IDX_W-1:0]         found_index_o,
  output logic signed [oaids_pkg::DATA_W-1:0] read_value_o,
  output logic [oaids_pkg::CNT_W-1:0]         fill_count_o
);

  localparam int DEPTH  = oaids_pkg::DEPTH;
  localparam int DATA_W = oaids_pkg::DATA_W;
  localparam int IDX_W  = oaids_pkg::IDX_W;
  localparam int CNT_W  = oaids_pkg::CNT_W;

  logic [oaids_pkg::ACT_W-1:0] act_q;
  logic [IDX_W-1:0]            pos_q;
  logic [DATA_W-1:0]           val_q;

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [DATA_W-1:0] entry_d [DEPTH];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DEPTH-1:0]  match_q, match_d;

  oaids_pkg::status_e stat_x;
  logic [DATA_W-1:0]  rd_x;
  logic [CNT_W-1:0]   pos_ext;
  logic               full;

  oaids_pkg::status_e srch_stat;
  logic [IDX_W-1:0]   srch_idx;

  oaids_pkg::status_e out_stat_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [DATA_W-1:0]  out_rd_q;
  logic [CNT_W-1:0]   out_cnt_q;

  assign pos_ext = {{(CNT_W-IDX_W){1'b0}}, pos_q};
  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.is_search = (act_q == oaids_pkg::ACT_SEARCH);

  always_comb begin
    entry_d = entry_q;
    cnt_d   = cnt_q;
    stat_x  = oaids_pkg::STAT_OK;
    rd_x    = '0;
    case (oaids_pkg::action_e'(act_q))
      oaids_pkg::ACT_APPEND: begin
        if (full) begin
          stat_x = oaids_pkg::STAT_FULL;
        end else begin
          entry_d[cnt_q[IDX_W-1:0]] = val_q;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      oaids_pkg::ACT_INSERT: begin
        if (full) begin
          stat_x = oaids_pkg::STAT_FULL;
        end else if (pos_ext > cnt_q) begin
          stat_x = oaids_pkg::STAT_BAD_POS;
        end else begin
          for (int i = 1; i < DEPTH; i++) begin
            if (IDX_W'(i) > pos_q) begin
              entry_d[i] = entry_q[i-1];
            end
          end
          entry_d[pos_q] = val_q;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      oaids_pkg::ACT_DELETE: begin
        if (pos_ext >= cnt_q) begin
          stat_x = oaids_pkg::STAT_BAD_POS;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= pos_q) begin
              entry_d[i] = entry_q[i+1];
            end
          end
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      oaids_pkg::ACT_READ: begin
        if (pos_ext >= cnt_q) begin
          stat_x = oaids_pkg::STAT_BAD_POS;
        end else begin
          rd_x = entry_q[pos_q];
        end
      end
      default: begin
        stat_x = oaids_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (entry_q[i] == val_q) && (CNT_W'(i) < cnt_q);
    end
  end

  always_comb begin
    srch_stat = oaids_pkg::STAT_NOT_FOUND;
    srch_idx  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        srch_stat = oaids_pkg::STAT_OK;
        srch_idx  = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.commit) begin
      entry_q    <= entry_d;
      out_stat_q <= stat_x;
      out_idx_q  <= '0;
      out_rd_q   <= rd_x;
      out_cnt_q  <= cnt_d;
    end
    if (cmd_i.match_load) begin
      match_q <= match_d;
    end
    if (cmd_i.srch_load) begin
      out_stat_q <= srch_stat;
      out_idx_q  <= srch_idx;
      out_rd_q   <= '0;
      out_cnt_q  <= cnt_q;
    end
  end

  assign status_o      = out_stat_q;
  assign found_index_o = out_idx_q;
  assign read_value_o  = out_rd_q;
  assign fill_count_o  = out_cnt_q;

endmodule

FILE: design/ordered_array_insert_delete_search.sv
// Ordered array store: a request passes the request register, then the
// result register; a search also passes the match vector, registered before
// the priority encoder. One request is in work at a time: a new one is taken
// only once the last result is registered, which waits while results stall.
// Reset clears the fill count and the handshake state; entries are undefined
// until written. Depends on oaids_pkg, oaids_ctrl and oaids_dp.
module ordered_array_insert_delete_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [oaids_pkg::ACT_W-1:0]         action_i,
  input  logic [oaids_pkg::IDX_W-1:0]         position_i,
  input  logic signed [oaids_pkg::DATA_W-1:0] value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [oaids_pkg::STAT_W-1:0]        status_o,
  output logic [oaids_pkg::IDX_W-1:0]         found_index_o,
  output logic signed [oaids_pkg::DATA_W-1:0] read_value_o,
  output logic [oaids_pkg::CNT_W-1:0]         fill_count_o
);

  oaids_pkg::ctrl_cmd_t cmd;
  oaids_pkg::dp_stat_t  stat;

  oaids_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  oaids_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (read_value_o),
    .fill_count_o  (fill_count_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while a request was still in work");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_count_o <= oaids_pkg::CNT_W'(oaids_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == oaids_pkg::STAT_FULL
      |-> fill_count_o == oaids_pkg::CNT_W'(oaids_pkg::DEPTH))
    else $error("full status reported below depth");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_index_o != '0 |-> status_o == oaids_pkg::STAT_OK)
    else $error("found index set without ok status");
`endif

endmodule
